// File: rtl/core/assert_macros.svh
// assertion helpers used by pdc_frame_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pdc_pkg.sv
package pdc_pkg;

    // input operation codes
    typedef enum logic
    {
        OP_ARM  = 1'b0,
        OP_BYTE = 1'b1
    } pdc_op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_ID         = 2'd0;
    localparam logic [1:0] CFG_BROADCAST_ID    = 2'd1;
    localparam logic [1:0] CFG_IGNORE_CRC_MASK = 2'd2;

    // configuration reset values
    localparam logic [7:0] NODE_ID_RESET         = 8'd101;
    localparam logic [7:0] BROADCAST_ID_RESET    = 8'd255;
    localparam logic [7:0] IGNORE_CRC_MASK_RESET = 8'd128;

    // error bits
    localparam logic [5:0] ERR_INIT   = 6'h01;
    localparam logic [5:0] ERR_LENGTH = 6'h02;
    localparam logic [5:0] ERR_SHORT  = 6'h04;
    localparam logic [5:0] ERR_LONG   = 6'h08;
    localparam logic [5:0] ERR_RECIP  = 6'h10;
    localparam logic [5:0] ERR_CRC    = 6'h20;

    // frame layout
    localparam logic [7:0] FRAME_OVERHEAD = 8'd9;
    localparam logic [15:0] CRC_SEED      = 16'hAAAA;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // byte positions of the header, relative to the first payload byte
    localparam logic signed [8:0] POS_LENGTH    = -9'sd7;
    localparam logic signed [8:0] POS_SENDER    = -9'sd6;
    localparam logic signed [8:0] POS_RECIPIENT = -9'sd5;
    localparam logic signed [8:0] POS_FLAGS     = -9'sd4;
    localparam logic signed [8:0] POS_TYPE      = -9'sd3;
    localparam logic signed [8:0] POS_MSGID_HI  = -9'sd2;
    localparam logic signed [8:0] POS_MSGID_LO  = -9'sd1;

    typedef struct packed
    {
        pdc_op_t    operation;
        logic [7:0] rx_byte;
    } pdc_in_t;

    typedef struct packed
    {
        logic        receiving;
        logic        frame_done;
        logic        payload_valid;
        logic [5:0]  payload_index;
        logic [7:0]  payload_byte;
        logic [7:0]  sender_addr;
        logic [7:0]  recipient_addr;
        logic [7:0]  frame_flags;
        logic [7:0]  frame_type;
        logic [15:0] message_number;
        logic [7:0]  payload_length;
        logic [5:0]  error_bits;
    } pdc_res_t;

    typedef struct packed
    {
        logic [7:0] node_id;
        logic [7:0] broadcast_id;
        logic [7:0] ignore_crc_mask;
    } pdc_cfg_t;

    // reflected crc-16 over one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/pdc_stream_if.sv
interface pdc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/pdc_in_stage.sv
module pdc_in_stage
    import pdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  pdc_in_t in_data,
    output logic    beat_valid,
    input  logic    beat_take,
    output pdc_in_t beat_data
);

    logic    valid_reg;
    pdc_in_t data_reg;

    // accept when empty or when the held beat moves on this cycle
    assign in_ready = !valid_reg || beat_take;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign beat_valid = valid_reg;
    assign beat_data  = data_reg;

endmodule

// File: rtl/core/pdc_frame_core.sv
`include "assert_macros.svh"

module pdc_frame_core
    import pdc_pkg::*;
#(
    parameter int MAX_PACKET_LEN = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  pdc_cfg_t cfg,
    input  logic     beat_valid,
    output logic     beat_take,
    input  pdc_in_t  beat_data,
    output logic     res_valid,
    input  logic     res_ready,
    output pdc_res_t res_data
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PACKET_LEN);

    logic              rx_active_reg,  rx_active_next;
    logic signed [8:0] pos_reg,        pos_next;
    logic [7:0]        length_reg,     length_next;
    logic [7:0]        sender_reg,     sender_next;
    logic [7:0]        recipient_reg,  recipient_next;
    logic [7:0]        flags_reg,      flags_next;
    logic [7:0]        type_reg,       type_next;
    logic [15:0]       msgid_reg,      msgid_next;
    logic [15:0]       crc_reg,        crc_next;
    logic [15:0]       rx_crc_reg,     rx_crc_next;
    logic [5:0]        error_reg,      error_next;
    logic              res_valid_reg;
    pdc_res_t          res_reg;
    pdc_res_t          res_next;
    logic              advance;
    logic              update;
    logic [8:0]        pos_delta;
    logic [7:0]        b;

    // a beat moves on when the result register is free
    assign advance   = beat_valid && (!res_valid_reg || res_ready);
    assign beat_take = advance;
    assign b         = beat_data.rx_byte;
    assign pos_delta = pos_reg - $signed({1'b0, length_reg});

    // frame parser
    always_comb
    begin
        rx_active_next = rx_active_reg;
        pos_next       = pos_reg;
        length_next    = length_reg;
        sender_next    = sender_reg;
        recipient_next = recipient_reg;
        flags_next     = flags_reg;
        type_next      = type_reg;
        msgid_next     = msgid_reg;
        crc_next       = crc_reg;
        rx_crc_next    = rx_crc_reg;
        error_next     = error_reg;
        update         = 1'b0;
        res_next       = '0;

        if (beat_data.operation == OP_ARM)
        begin
            error_next     = ERR_INIT;
            flags_next     = '0;
            sender_next    = '0;
            recipient_next = '0;
            type_next      = '0;
            crc_next       = CRC_SEED;
            rx_crc_next    = CRC_SEED;
            pos_next       = POS_LENGTH;
            rx_active_next = 1'b1;
        end
        else if (rx_active_reg)
        begin
            update = 1'b1;
            case (pos_reg)
                POS_LENGTH:
                begin
                    error_next  = '0;
                    length_next = b - FRAME_OVERHEAD;
                    if (b < FRAME_OVERHEAD)
                    begin
                        error_next          = ERR_LENGTH | ERR_SHORT;
                        rx_active_next      = 1'b0;
                        res_next.frame_done = 1'b1;
                    end
                    else if (b > MAX_LEN)
                    begin
                        error_next          = ERR_LENGTH | ERR_LONG;
                        rx_active_next      = 1'b0;
                        res_next.frame_done = 1'b1;
                    end
                end
                POS_SENDER:
                begin
                    sender_next = b;
                end
                POS_RECIPIENT:
                begin
                    recipient_next = b;
                    if (b != cfg.node_id && b != cfg.broadcast_id)
                    begin
                        error_next = error_reg | ERR_RECIP;
                    end
                end
                POS_FLAGS:
                begin
                    flags_next = b;
                end
                POS_TYPE:
                begin
                    type_next = b;
                end
                POS_MSGID_HI:
                begin
                    msgid_next = {b, 8'h00};
                end
                POS_MSGID_LO:
                begin
                    msgid_next = msgid_reg | {8'h00, b};
                end
                default:
                begin
                    // payload, then the two crc bytes
                    if ($unsigned(pos_reg) < {1'b0, length_reg})
                    begin
                        res_next.payload_valid = 1'b1;
                        res_next.payload_index = pos_reg[5:0];
                        res_next.payload_byte  = b;
                    end
                    else
                    begin
                        update = 1'b0;
                        if (pos_delta == 9'd0)
                        begin
                            rx_crc_next = {b, 8'h00};
                            pos_next    = pos_reg + 9'sd1;
                        end
                        else if (pos_delta == 9'd1)
                        begin
                            rx_active_next      = 1'b0;
                            res_next.frame_done = 1'b1;
                            rx_crc_next         = rx_crc_reg | {8'h00, b};
                            if (rx_crc_next != crc_reg && (flags_reg & cfg.ignore_crc_mask) == '0)
                            begin
                                error_next = error_reg | ERR_CRC;
                            end
                            pos_next = pos_reg + 9'sd1;
                        end
                        else
                        begin
                            rx_active_next = 1'b0;
                        end
                    end
                end
            endcase
            if (update)
            begin
                pos_next = pos_reg + 9'sd1;
                crc_next = crc16_byte(crc_reg, b);
            end
        end

        res_next.receiving      = rx_active_next;
        res_next.sender_addr    = sender_next;
        res_next.recipient_addr = recipient_next;
        res_next.frame_flags    = flags_next;
        res_next.frame_type     = type_next;
        res_next.message_number = msgid_next;
        res_next.payload_length = length_next;
        res_next.error_bits     = error_next;
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_active_reg <= 1'b0;
            pos_reg       <= POS_LENGTH;
            length_reg    <= '0;
            sender_reg    <= '0;
            recipient_reg <= '0;
            flags_reg     <= '0;
            type_reg      <= '0;
            msgid_reg     <= '0;
            crc_reg       <= CRC_SEED;
            rx_crc_reg    <= CRC_SEED;
            error_reg     <= ERR_INIT;
        end
        else if (advance)
        begin
            rx_active_reg <= rx_active_next;
            pos_reg       <= pos_next;
            length_reg    <= length_next;
            sender_reg    <= sender_next;
            recipient_reg <= recipient_next;
            flags_reg     <= flags_next;
            type_reg      <= type_next;
            msgid_reg     <= msgid_next;
            crc_reg       <= crc_next;
            rx_crc_reg    <= rx_crc_next;
            error_reg     <= error_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // checks
    `PDC_ASSERT_NEXT(a_arm_starts, clk, rst_n,
        advance && beat_data.operation == OP_ARM,
        rx_active_reg && pos_reg == POS_LENGTH && error_reg == ERR_INIT,
        "arm did not start a frame")
    `PDC_ASSERT_NEXT(a_idle_byte_ignored, clk, rst_n,
        advance && beat_data.operation == OP_BYTE && !rx_active_reg,
        $stable(error_reg) && $stable(crc_reg) && $stable(pos_reg),
        "byte while idle changed frame state")
    `PDC_ASSERT_NEXT(a_result_loaded, clk, rst_n,
        advance,
        res_valid_reg,
        "accepted beat produced no result")

endmodule

// File: rtl/core/packet_deframer_crc16.sv
// packet_deframer_crc16: receive side of a length-prefixed radio packet
// with a reflected crc-16 trailer.
// bytes channel: one beat per operation, either an arm command or one
// received byte; results channel: one beat per input beat, carrying the
// frame status, any payload byte with its index, the header fields, the
// payload length and the error bits.
// configuration: cfg_write with cfg_index 0 node id, 1 broadcast id,
// 2 ignore-crc flags mask; other indexes are dropped. write only while idle.
// path: an accepted input beat is held in the input register, then passes
// the parser into the registered result. throughput: one beat per cycle
// while results are taken; the crc byte update is combinational.
// reset: the receiver is idle, error bits read init, crc seeds are 0xAAAA
// and the configuration registers take their default values.
// stall: while the results side holds off, the result register and the
// input register each hold one beat; then ready on the bytes side drops
// until the result is taken.
module packet_deframer_crc16
    import pdc_pkg::*;
#(
    parameter int MAX_PACKET_LEN = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    pdc_stream_if.sink   bytes,
    pdc_stream_if.source results,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    pdc_cfg_t cfg_reg;
    logic     beat_valid;
    logic     beat_take;
    pdc_in_t  beat_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id         <= NODE_ID_RESET;
            cfg_reg.broadcast_id    <= BROADCAST_ID_RESET;
            cfg_reg.ignore_crc_mask <= IGNORE_CRC_MASK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NODE_ID:         cfg_reg.node_id         <= cfg_data;
                CFG_BROADCAST_ID:    cfg_reg.broadcast_id    <= cfg_data;
                CFG_IGNORE_CRC_MASK: cfg_reg.ignore_crc_mask <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // input register
    pdc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (bytes.valid),
        .in_ready   (bytes.ready),
        .in_data    (bytes.data),
        .beat_valid (beat_valid),
        .beat_take  (beat_take),
        .beat_data  (beat_data)
    );

    // parser and result register
    pdc_frame_core #(
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    ) u_frame_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .beat_valid (beat_valid),
        .beat_take  (beat_take),
        .beat_data  (beat_data),
        .res_valid  (results.valid),
        .res_ready  (results.ready),
        .res_data   (results.data)
    );

endmodule

// File: sim/packet_deframer_crc16_checker.sv
module packet_deframer_crc16_checker
    import pdc_pkg::*;
#(
    parameter int MAX_PACKET_LEN = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  pdc_in_t    in_beat,
    input  logic       out_valid,
    input  logic       out_ready,
    input  pdc_res_t   out_beat,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         outstanding,
    output int         fail_count
);

    // own copy of the receiver state
    logic        rx_on;
    int          pos;
    logic [7:0]  len_q;
    logic [7:0]  src_q;
    logic [7:0]  dst_q;
    logic [7:0]  flg_q;
    logic [7:0]  typ_q;
    logic [15:0] msg_q;
    logic [15:0] crc_run;
    logic [15:0] crc_rx;
    logic [5:0]  err_q;

    // own copy of the configuration
    logic [7:0]  my_node;
    logic [7:0]  my_bcast;
    logic [7:0]  crc_skip_mask;

    // frame status words still owed by the block, oldest first
    pdc_res_t    frame_status_q[$];

    // reflected crc-16, one input bit folded in per step
    function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = c;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // advance the receiver by one beat and return the status it shows
    task automatic deframe_beat(input pdc_in_t beat, output pdc_res_t r);
        logic feed;
        int   tail;
        logic [7:0] b;
        b    = beat.rx_byte;
        feed = 1'b1;
        r    = '0;
        if (beat.operation == OP_ARM)
        begin
            // arm keeps the length and message id registers
            err_q   = ERR_INIT;
            flg_q   = '0;
            src_q   = '0;
            dst_q   = '0;
            typ_q   = '0;
            crc_run = CRC_SEED;
            crc_rx  = CRC_SEED;
            pos     = int'(POS_LENGTH);
            rx_on   = 1'b1;
        end
        else if (rx_on)
        begin
            case (pos)
                POS_LENGTH:
                begin
                    err_q = '0;
                    len_q = b - FRAME_OVERHEAD;
                    if (b < FRAME_OVERHEAD)
                    begin
                        err_q        = err_q | ERR_LENGTH | ERR_SHORT;
                        rx_on        = 1'b0;
                        r.frame_done = 1'b1;
                    end
                    else if (int'(b) > MAX_PACKET_LEN)
                    begin
                        err_q        = err_q | ERR_LENGTH | ERR_LONG;
                        rx_on        = 1'b0;
                        r.frame_done = 1'b1;
                    end
                end
                POS_SENDER:    src_q = b;
                POS_RECIPIENT:
                begin
                    dst_q = b;
                    if (b != my_node && b != my_bcast)
                        err_q = err_q | ERR_RECIP;
                end
                POS_FLAGS:     flg_q = b;
                POS_TYPE:      typ_q = b;
                POS_MSGID_HI:  msg_q = {b, 8'h00};
                POS_MSGID_LO:  msg_q = {msg_q[15:8], b};
                default:
                begin
                    if (pos < int'(len_q))
                    begin
                        // payload beat, passed straight through
                        r.payload_valid = 1'b1;
                        r.payload_index = pos[5:0];
                        r.payload_byte  = b;
                    end
                    else
                    begin
                        // crc trailer, big-endian, not fed into the crc
                        feed = 1'b0;
                        tail = pos - int'(len_q);
                        if (tail == 0)
                        begin
                            crc_rx = {b, 8'h00};
                            pos++;
                        end
                        else if (tail == 1)
                        begin
                            rx_on        = 1'b0;
                            r.frame_done = 1'b1;
                            crc_rx       = {crc_rx[15:8], b};
                            if (crc_rx != crc_run && (flg_q & crc_skip_mask) == '0)
                                err_q = err_q | ERR_CRC;
                            pos++;
                        end
                        else
                        begin
                            rx_on = 1'b0;
                        end
                    end
                end
            endcase
            if (feed)
            begin
                pos++;
                crc_run = crc16_fold(crc_run, b);
            end
        end
        r.receiving      = rx_on;
        r.sender_addr    = src_q;
        r.recipient_addr = dst_q;
        r.frame_flags    = flg_q;
        r.frame_type     = typ_q;
        r.message_number = msg_q;
        r.payload_length = len_q;
        r.error_bits     = err_q;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // compare results, then predict from new input beats, then track config
    always @(posedge clk or negedge rst_n)
    begin
        pdc_res_t want;
        pdc_res_t next_status;
        if (!rst_n)
        begin
            rx_on         = 1'b0;
            pos           = int'(POS_LENGTH);
            len_q         = '0;
            src_q         = '0;
            dst_q         = '0;
            flg_q         = '0;
            typ_q         = '0;
            msg_q         = '0;
            crc_run       = CRC_SEED;
            crc_rx        = CRC_SEED;
            err_q         = ERR_INIT;
            my_node       = NODE_ID_RESET;
            my_bcast      = BROADCAST_ID_RESET;
            crc_skip_mask = IGNORE_CRC_MASK_RESET;
            fail_count    = 0;
            frame_status_q.delete();
            outstanding  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_status_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, out_beat);
                    fail_count++;
                end
                else
                begin
                    want = frame_status_q.pop_front();
                    check_field("receiving", 16'(want.receiving),
                                16'(out_beat.receiving));
                    check_field("frame_done", 16'(want.frame_done),
                                16'(out_beat.frame_done));
                    check_field("payload_valid", 16'(want.payload_valid),
                                16'(out_beat.payload_valid));
                    check_field("payload_index", 16'(want.payload_index),
                                16'(out_beat.payload_index));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(out_beat.payload_byte));
                    check_field("sender_addr", 16'(want.sender_addr),
                                16'(out_beat.sender_addr));
                    check_field("recipient_addr", 16'(want.recipient_addr),
                                16'(out_beat.recipient_addr));
                    check_field("frame_flags", 16'(want.frame_flags),
                                16'(out_beat.frame_flags));
                    check_field("frame_type", 16'(want.frame_type),
                                16'(out_beat.frame_type));
                    check_field("message_number", want.message_number,
                                out_beat.message_number);
                    check_field("payload_length", 16'(want.payload_length),
                                16'(out_beat.payload_length));
                    check_field("error_bits", 16'(want.error_bits),
                                16'(out_beat.error_bits));
                end
            end
            if (in_valid && in_ready)
            begin
                deframe_beat(in_beat, next_status);
                frame_status_q.push_back(next_status);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NODE_ID:         my_node       = cfg_data;
                    CFG_BROADCAST_ID:    my_bcast      = cfg_data;
                    CFG_IGNORE_CRC_MASK: crc_skip_mask = cfg_data;
                    default:             ;
                endcase
            end
            outstanding <= frame_status_q.size();
        end
    end

endmodule

// File: sim/packet_deframer_crc16_tb.sv
module packet_deframer_crc16_tb;
    import pdc_pkg::*;

    localparam int MAX_PACKET_LEN = 64;
    localparam int ITEM_TARGET    = 1750;
    localparam int PHASE_ITEMS    = 350;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    int         outstanding;
    int         fail_count;
    int         items_sent;
    int         idle_cycles;
    int         stall_left;
    logic       steady_tx;
    logic       steady_rx;

    // configuration currently loaded, used to aim recipients and flags
    logic [7:0] cur_node;
    logic [7:0] cur_bcast;
    logic [7:0] cur_mask;

    pdc_stream_if #(.payload_t(pdc_in_t))  bytes_if ();
    pdc_stream_if #(.payload_t(pdc_res_t)) results_if ();

    packet_deframer_crc16 #(
        .MAX_PACKET_LEN(MAX_PACKET_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes_if),
        .results   (results_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    packet_deframer_crc16_checker #(
        .MAX_PACKET_LEN(MAX_PACKET_LEN)
    ) frame_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (bytes_if.valid),
        .in_ready    (bytes_if.ready),
        .in_beat     (bytes_if.data),
        .out_valid   (results_if.valid),
        .out_ready   (results_if.ready),
        .out_beat    (results_if.data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always #5 clk = ~clk;

    // results side: mostly ready, short stalls, now and then a long one
    always @(posedge clk)
    begin
        int roll;
        if (!rst_n || steady_rx)
        begin
            results_if.ready <= rst_n;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            results_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                results_if.ready <= 1'b1;
            else
            begin
                results_if.ready <= 1'b0;
                if (roll < 92)
                    stall_left = $urandom_range(0, 2);
                else
                    stall_left = $urandom_range(7, 39);
            end
        end
    end

    // watchdog on cycles where neither channel moves a beat
    always @(posedge clk)
    begin
        if (!rst_n || (bytes_if.valid && bytes_if.ready) ||
            (results_if.valid && results_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int sender_gap();
        int roll;
        if (steady_tx)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one beat on the bytes channel, valid left high for a following beat
    task automatic send_beat(input pdc_op_t op, input logic [7:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_if.valid <= 1'b1;
        bytes_if.data  <= '{operation: op, rx_byte: b};
        do
            @(posedge clk);
        while (!bytes_if.ready);
    endtask

    // stop sending and wait until every status word has come back
    task automatic drain();
        bytes_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_ids(input logic [7:0] node, input logic [7:0] bcast,
                               input logic [7:0] mask);
        cfg_write <= 1'b1;
        cfg_index <= CFG_NODE_ID;
        cfg_data  <= node;
        @(posedge clk);
        cfg_index <= CFG_BROADCAST_ID;
        cfg_data  <= bcast;
        @(posedge clk);
        cfg_index <= CFG_IGNORE_CRC_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_node  = node;
        cur_bcast = bcast;
        cur_mask  = mask;
    endtask

    // arm, then a length-prefixed frame; cut > 0 truncates it to that many bytes
    task automatic send_frame(input logic [7:0] total_len, input logic [7:0] dst,
                              input logic [7:0] flg, input bit bad_crc, input int cut);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          n;
        fb.push_back(total_len);
        if (total_len >= FRAME_OVERHEAD && int'(total_len) <= MAX_PACKET_LEN)
        begin
            fb.push_back(8'($urandom));
            fb.push_back(dst);
            fb.push_back(flg);
            repeat (3) fb.push_back(8'($urandom));
            n = int'(total_len) - int'(FRAME_OVERHEAD);
            repeat (n) fb.push_back(8'($urandom));
            crc = CRC_SEED;
            foreach (fb[i])
                crc = crc16_byte(crc, fb[i]);
            if (bad_crc)
                crc = crc ^ 16'($urandom_range(1, 65535));
            fb.push_back(crc[15:8]);
            fb.push_back(crc[7:0]);
        end
        if (cut > 0 && cut < fb.size())
            fb = fb[0:cut-1];
        send_beat(OP_ARM, 8'($urandom));
        foreach (fb[i])
            send_beat(OP_BYTE, fb[i]);
        items_sent += fb.size() + 1;
    endtask

    initial
    begin
        int         phase;
        int         roll;
        int         cut;
        logic [7:0] total_len;
        logic [7:0] dst;
        logic [7:0] flg;
        clk              = 1'b0;
        rst_n            = 1'b0;
        bytes_if.valid   = 1'b0;
        bytes_if.data    = '0;
        results_if.ready = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = CFG_NODE_ID;
        cfg_data         = '0;
        steady_tx        = 1'b0;
        steady_rx        = 1'b0;
        items_sent       = 0;
        cur_node         = NODE_ID_RESET;
        cur_bcast        = BROADCAST_ID_RESET;
        cur_mask         = IGNORE_CRC_MASK_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle bytes, length limits, a header-only frame with errors
        send_beat(OP_BYTE, 8'hFF);
        send_frame(8'd0, 8'h00, 8'h00, 1'b0, 0);
        send_frame(8'd8, 8'h00, 8'h00, 1'b0, 0);
        send_frame(8'd65, 8'h00, 8'h00, 1'b0, 0);
        send_frame(8'd255, 8'h00, 8'h00, 1'b0, 0);
        send_frame(8'd9, 8'h12, 8'h00, 1'b1, 0);
        send_beat(OP_BYTE, 8'h00);
        items_sent = 0;

        // random frames, configuration changed between phases
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent / PHASE_ITEMS != phase)
            begin
                phase = items_sent / PHASE_ITEMS;
                drain();
                case (phase % 5)
                    1:       program_ids(8'h00, 8'h00, 8'h00);
                    2:       program_ids(8'hFF, 8'hFF, 8'hFF);
                    3:       program_ids(8'($urandom), 8'($urandom),
                                         8'(1 << $urandom_range(0, 7)));
                    4:       program_ids(8'($urandom), BROADCAST_ID_RESET,
                                         IGNORE_CRC_MASK_RESET);
                    default: program_ids(8'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            if ($urandom_range(0, 19) == 0)
                steady_tx <= !steady_tx;
            if ($urandom_range(0, 19) == 0)
                steady_rx <= !steady_rx;

            // frame length: mostly short payloads, some limits and bad lengths
            roll = $urandom_range(0, 99);
            if (roll < 5)
                total_len = 8'($urandom_range(0, 8));
            else if (roll < 10)
                total_len = 8'($urandom_range(MAX_PACKET_LEN + 1, 255));
            else if (roll < 15)
                total_len = ($urandom_range(0, 1) != 0) ? 8'(MAX_PACKET_LEN) : FRAME_OVERHEAD;
            else if (roll < 22)
                total_len = 8'($urandom_range(21, MAX_PACKET_LEN));
            else
                total_len = 8'($urandom_range(9, 20));

            roll = $urandom_range(0, 99);
            if (roll < 45)
                dst = cur_node;
            else if (roll < 70)
                dst = cur_bcast;
            else
                dst = 8'($urandom);

            flg = 8'($urandom);
            roll = $urandom_range(0, 2);
            if (roll == 0)
                flg = flg | cur_mask;
            else if (roll == 1)
                flg = flg & ~cur_mask;

            cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, int'(total_len) + 2) : 0;
            send_frame(total_len, dst, flg, $urandom_range(0, 99) < 20, cut);

            // stray bytes after a finished frame are ignored by the block
            if (cut == 0 && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) send_beat(OP_BYTE, 8'($urandom));
        end

        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pdc_pkg.sv
rtl/core/pdc_stream_if.sv
rtl/core/pdc_in_stage.sv
rtl/core/pdc_frame_core.sv
rtl/core/packet_deframer_crc16.sv
sim/packet_deframer_crc16_checker.sv
sim/packet_deframer_crc16_tb.sv
